### rtl/tdk_pkg.sv
// Types, constants and record builders for the tap-dance key tracker.
// Used by tdk_seq and the top level; no dependencies.
`default_nettype none
package tdk_pkg;

    localparam int DANCE_KEYS = 16;
    localparam int IDX_W = (DANCE_KEYS > 1) ? $clog2(DANCE_KEYS) : 1;
    localparam logic [15:0] TAP_WINDOW_RST = 16'd200;
    localparam logic [7:0] CNT_MAX = 8'd255;

    typedef enum logic [2:0] {
        ACT_TAP,
        ACT_HOLD,
        ACT_INTERRUPT,
        ACT_TIMEOUT,
        ACT_RELEASE
    } t_act;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_T_EV,
        S_INT_EM,
        S_TAP,
        S_HOLD,
        S_SCAN,
        S_SCAN_EM,
        S_TO_CHK,
        S_TO_EM,
        S_VERDICT
    } t_state;

    typedef struct packed {
        logic        action;
        logic        key_is_dance;
        logic [3:0]  dance_index;
        logic [7:0]  row;
        logic [7:0]  col;
        logic        now_pressed;
        logic        prev_pressed;
        logic        injected;
        logic        key_masked;
        logic [31:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic       result_kind;
        logic [3:0] dance_index_res;
        logic [7:0] taps_so_far;
        logic [2:0] dance_action;
        logic [7:0] row_res;
        logic [7:0] col_res;
        logic       verdict;
        logic       mask_key;
        logic       unmask_key;
        logic       flush_report;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic [7:0] cnt;
        logic       held;
        logic       fired;
    } t_entry;

    typedef struct packed {
        logic             re;
        logic [IDX_W-1:0] raddr;
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_entry           wdata;
    } t_ram_req;

    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_emit;

    function automatic t_out_item act_rec(input logic [IDX_W-1:0] idx, input logic [7:0] cnt,
                                          input t_act act, input logic [7:0] row,
                                          input logic [7:0] col);
        t_out_item o;
        o = '0;
        o.dance_index_res = 4'(idx);
        o.taps_so_far = cnt;
        o.dance_action = act;
        o.row_res = row;
        o.col_res = col;
        return o;
    endfunction

    function automatic t_out_item verd_rec(input logic c, input logic m, input logic u,
                                           input logic f);
        t_out_item o;
        o = '0;
        o.result_kind = 1'b1;
        o.verdict = c;
        o.mask_key = m;
        o.unmask_key = u;
        o.flush_report = f;
        o.last = 1'b1;
        return o;
    endfunction

endpackage
`default_nettype wire

### rtl/tdk_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module tdk_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 10,
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

### rtl/tdk_seq.sv
// Sequencer of the tap-dance key tracker: read-modify-write of the per-key
// table, active dance state and result emission. Depends on tdk_pkg.
`default_nettype none
module tdk_seq (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire tdk_pkg::t_in_item       i_in_item,
    input  wire logic [15:0]             i_win,
    input  wire logic                    i_out_free,
    output tdk_pkg::t_emit               o_emit,
    output tdk_pkg::t_ram_req            o_ram,
    input  wire logic [$bits(tdk_pkg::t_entry)-1:0] i_ram_q
);
    import tdk_pkg::*;

    localparam logic [IDX_W-1:0] LAST = IDX_W'(DANCE_KEYS - 1);

    t_state           r_state, n_state;
    t_in_item         r_it, n_it;
    logic             r_act_vld, n_act_vld;
    logic [IDX_W-1:0] r_ai, n_ai;
    logic [7:0]       r_arow, n_arow, r_acol, n_acol;
    logic [31:0]      r_deadline, n_deadline;
    logic [DANCE_KEYS-1:0] r_rp, n_rp, r_vld, n_vld;
    logic             r_rdv, n_rdv;
    logic [IDX_W-1:0] r_i, n_i;
    logic [7:0]       r_tc, n_tc;
    logic             r_th, n_th, r_tf, n_tf;
    logic             r_vc, n_vc, r_vm, n_vm, r_vu, n_vu, r_vf, n_vf;
    logic             r_int_dance, n_int_dance;

    t_entry           q;
    logic             on, off, in_rng;
    logic [IDX_W-1:0] t;
    logic [7:0]       cnt_inc;

    assign q = r_rdv ? t_entry'(i_ram_q) : '0;
    assign on = r_it.now_pressed & ~r_it.prev_pressed;
    assign off = ~r_it.now_pressed & r_it.prev_pressed;
    assign in_rng = (7'(r_it.dance_index) < 7'(DANCE_KEYS));
    assign t = IDX_W'(r_it.dance_index);
    assign cnt_inc = (r_tc == CNT_MAX) ? r_tc : r_tc + 8'd1;
    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_act_vld <= 1'b0;
            r_ai <= '0;
            r_arow <= '0;
            r_acol <= '0;
            r_deadline <= '0;
            r_rp <= '0;
            r_vld <= '0;
        end else begin
            r_state <= n_state;
            r_act_vld <= n_act_vld;
            r_ai <= n_ai;
            r_arow <= n_arow;
            r_acol <= n_acol;
            r_deadline <= n_deadline;
            r_rp <= n_rp;
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_it <= n_it;
        r_rdv <= n_rdv;
        r_i <= n_i;
        r_tc <= n_tc;
        r_th <= n_th;
        r_tf <= n_tf;
        r_vc <= n_vc;
        r_vm <= n_vm;
        r_vu <= n_vu;
        r_vf <= n_vf;
        r_int_dance <= n_int_dance;
    end

    always_comb begin
        n_state = r_state;
        n_it = r_it;
        n_act_vld = r_act_vld;
        n_ai = r_ai;
        n_arow = r_arow;
        n_acol = r_acol;
        n_deadline = r_deadline;
        n_rp = r_rp;
        n_vld = r_vld;
        n_rdv = r_rdv;
        n_i = r_i;
        n_tc = r_tc;
        n_th = r_th;
        n_tf = r_tf;
        n_vc = r_vc;
        n_vm = r_vm;
        n_vu = r_vu;
        n_vf = r_vf;
        n_int_dance = r_int_dance;
        o_ram = '0;
        o_emit = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_it = i_in_item;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                {n_vc, n_vm, n_vu, n_vf} = 4'b0000;
                if (r_it.action) begin
                    n_i = '0;
                    n_state = S_SCAN;
                end else if (r_it.injected) begin
                    n_state = S_VERDICT;
                end else if (!r_it.key_is_dance || !in_rng) begin
                    if (r_act_vld && on) begin
                        o_ram.re = 1'b1;
                        o_ram.raddr = r_ai;
                        n_rdv = r_vld[r_ai];
                        n_int_dance = 1'b0;
                        n_state = S_INT_EM;
                    end else begin
                        if (r_act_vld) begin
                            n_vc = r_it.key_masked;
                            n_vu = r_it.key_masked;
                        end
                        n_state = S_VERDICT;
                    end
                end else begin
                    o_ram.re = 1'b1;
                    o_ram.raddr = t;
                    n_rdv = r_vld[t];
                    n_state = S_T_EV;
                end
            end
            S_T_EV: begin
                n_tc = q.cnt;
                n_tf = q.fired;
                n_th = off ? 1'b0 : q.held;
                {n_vc, n_vm, n_vu, n_vf} = 4'b1000;
                n_state = S_VERDICT;
                o_ram.waddr = t;
                o_ram.wdata = '{cnt: q.cnt, held: 1'b0, fired: q.fired};
                if (!(r_act_vld && r_ai == t)) begin
                    if (!r_act_vld) begin
                        if (q.fired) begin
                            if (off) begin
                                o_ram.we = 1'b1;
                                o_ram.wdata.fired = 1'b0;
                                n_rp[t] = 1'b1;
                                n_deadline = '0;
                            end
                        end else begin
                            n_act_vld = 1'b1;
                            n_ai = t;
                            n_arow = r_it.row;
                            n_acol = r_it.col;
                            n_state = S_TAP;
                        end
                    end else if (off && q.cnt != 8'd0) begin
                        o_ram.we = 1'b1;
                        o_ram.wdata.fired = 1'b0;
                        n_rp[t] = 1'b1;
                        n_deadline = '0;
                        n_act_vld = 1'b0;
                    end else if (!on) begin
                        o_ram.we = off;
                    end else begin
                        o_ram.re = 1'b1;
                        o_ram.raddr = r_ai;
                        n_rdv = r_vld[r_ai];
                        n_int_dance = 1'b1;
                        n_state = S_INT_EM;
                    end
                end else if (off) begin
                    o_ram.we = 1'b1;
                end else begin
                    n_arow = r_it.row;
                    n_acol = r_it.col;
                    n_th = 1'b1;
                    if (on) begin
                        n_state = S_TAP;
                    end else begin
                        o_ram.we = 1'b1;
                        o_ram.wdata.held = 1'b1;
                        if (q.fired) begin
                            n_state = S_HOLD;
                        end
                    end
                end
                if (o_ram.we) begin
                    n_vld[t] = 1'b1;
                end
            end
            S_INT_EM: begin
                if (i_out_free) begin
                    o_emit.valid = 1'b1;
                    o_emit.item = act_rec(r_ai, q.cnt, ACT_INTERRUPT, r_arow, r_acol);
                    o_ram.we = 1'b1;
                    o_ram.waddr = r_ai;
                    n_vld[r_ai] = 1'b1;
                    n_deadline = '0;
                    if (q.held) begin
                        o_ram.wdata = '{cnt: q.cnt, held: 1'b1, fired: 1'b1};
                    end else begin
                        o_ram.wdata = '{cnt: q.cnt, held: 1'b0, fired: 1'b0};
                        n_rp[r_ai] = 1'b1;
                        n_act_vld = 1'b0;
                    end
                    if (r_int_dance) begin
                        n_act_vld = 1'b1;
                        n_ai = t;
                        n_arow = r_it.row;
                        n_acol = r_it.col;
                        n_th = 1'b1;
                        {n_vc, n_vm, n_vu, n_vf} = 4'b1101;
                        n_state = S_TAP;
                    end else begin
                        {n_vc, n_vm, n_vu, n_vf} = 4'b1111;
                        n_state = S_VERDICT;
                    end
                end
            end
            S_TAP: begin
                if (i_out_free) begin
                    o_emit.valid = 1'b1;
                    o_emit.item = act_rec(r_ai, cnt_inc, ACT_TAP, r_arow, r_acol);
                    o_ram.we = 1'b1;
                    o_ram.waddr = r_ai;
                    o_ram.wdata = '{cnt: cnt_inc, held: r_th, fired: r_tf};
                    n_vld[r_ai] = 1'b1;
                    n_deadline = r_it.now_ms + 32'(i_win);
                    n_state = S_VERDICT;
                end
            end
            S_HOLD: begin
                if (i_out_free) begin
                    o_emit.valid = 1'b1;
                    o_emit.item = act_rec(r_ai, r_tc, ACT_HOLD, r_arow, r_acol);
                    n_state = S_VERDICT;
                end
            end
            S_SCAN: begin
                if (r_rp[r_i]) begin
                    o_ram.re = 1'b1;
                    o_ram.raddr = r_i;
                    n_rdv = r_vld[r_i];
                    n_state = S_SCAN_EM;
                end else if (r_i == LAST) begin
                    n_state = S_TO_CHK;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            S_SCAN_EM: begin
                if (i_out_free) begin
                    o_emit.valid = 1'b1;
                    o_emit.item = act_rec(r_i, q.cnt, ACT_RELEASE, r_arow, r_acol);
                    o_ram.we = 1'b1;
                    o_ram.waddr = r_i;
                    o_ram.wdata = '{cnt: 8'd0, held: q.held, fired: q.fired};
                    n_vld[r_i] = 1'b1;
                    n_rp[r_i] = 1'b0;
                    if (r_i == LAST) begin
                        n_state = S_TO_CHK;
                    end else begin
                        n_i = r_i + 1'b1;
                        n_state = S_SCAN;
                    end
                end
            end
            S_TO_CHK: begin
                if (r_act_vld && r_deadline != 32'd0 && r_it.now_ms > r_deadline) begin
                    o_ram.re = 1'b1;
                    o_ram.raddr = r_ai;
                    n_rdv = r_vld[r_ai];
                    n_state = S_TO_EM;
                end else begin
                    n_state = S_VERDICT;
                end
            end
            S_TO_EM: begin
                if (i_out_free) begin
                    o_emit.valid = 1'b1;
                    o_emit.item = act_rec(r_ai, q.cnt, ACT_TIMEOUT, r_arow, r_acol);
                    o_ram.we = 1'b1;
                    o_ram.waddr = r_ai;
                    n_vld[r_ai] = 1'b1;
                    if (q.held) begin
                        o_ram.wdata = '{cnt: q.cnt, held: 1'b1, fired: 1'b1};
                    end else begin
                        o_ram.wdata = '{cnt: q.cnt, held: 1'b0, fired: 1'b0};
                        n_rp[r_ai] = 1'b1;
                        n_act_vld = 1'b0;
                        n_deadline = '0;
                    end
                    n_state = S_VERDICT;
                end
            end
            S_VERDICT: begin
                if (i_out_free) begin
                    o_emit.valid = 1'b1;
                    o_emit.item = verd_rec(r_vc, r_vm, r_vu, r_vf);
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

### rtl/tap_dance_key_tracker.sv
// A key event's verdict follows any table read and any interrupt, tap or hold record; an
// end-of-scan item walks the whole table, emitting pending releases, then checks the dance
// timeout before its verdict. Output stalls lengthen both.
// Items are handled one at a time; the next is taken once the verdict is loaded.
// Reset clears the active dance, deadline, table valid and pending-release bits; the
// tap window returns to 200 ms. Top level: tapping-key tracker with table RAM.
`default_nettype none
module tap_dance_key_tracker (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire tdk_pkg::t_in_item   i_in_item,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output tdk_pkg::t_out_item       o_out_item,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [15:0]         i_cfg_data
);
    import tdk_pkg::*;

    logic [15:0] r_win;
    logic        r_ovld;
    t_out_item   r_oitem;
    logic        out_free;
    t_emit       emit;
    t_ram_req    ram;
    logic [$bits(t_entry)-1:0] ram_q;

    assign o_cfg_ready = 1'b1;
    assign out_free = !r_ovld || i_out_ready;
    assign o_out_valid = r_ovld;
    assign o_out_item = r_oitem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= TAP_WINDOW_RST;
            r_ovld <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_win <= i_cfg_data;
            end
            if (emit.valid) begin
                r_ovld <= 1'b1;
            end else if (i_out_ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit.valid) begin
            r_oitem <= emit.item;
        end
    end

    tdk_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_win      (r_win),
        .i_out_free (out_free),
        .o_emit     (emit),
        .o_ram      (ram),
        .i_ram_q    (ram_q)
    );

    tdk_ram #(
        .DEPTH (DANCE_KEYS),
        .WIDTH ($bits(t_entry)),
        .AW    (IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_re    (ram.re),
        .i_raddr (ram.raddr),
        .i_we    (ram.we),
        .i_waddr (ram.waddr),
        .i_wdata (ram.wdata),
        .o_rdata (ram_q)
    );
endmodule
`default_nettype wire

### tb/tb_tap_dance_key_tracker.sv
// Testbench for the tap-dance key tracker: random and directed key events and scan ends.
// Predicts the action and verdict records in-bench and checks them in order.
// Depends on tdk_pkg and tap_dance_key_tracker.
`timescale 1ns / 100ps
module tb_tap_dance_key_tracker;
    import tdk_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_ready;
    t_out_item out_item;
    logic      cfg_valid;
    logic      cfg_ready;
    logic [15:0] cfg_data;

    tap_dance_key_tracker i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_item(in_item),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_item(out_item),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_data(cfg_data)
    );

    t_in_item  pending_events[$];
    t_out_item expected_records[$];
    int        fail_count = 0;
    int        idle_cycles = 0;
    int        in_wait = 0;
    int        out_wait = 0;
    int        stall_hold = 0;
    bit        stall_request = 0;
    bit        stall_taken = 0;
    bit        in_ready_seen = 0;

    // tracker state
    logic [15:0] window_ms;
    logic        act_valid;
    logic [3:0]  act_idx;
    logic [7:0]  act_row, act_col;
    logic [31:0] deadline;
    logic [7:0]  counts[16];
    logic        held[16], fired[16], rel_pend[16];
    logic        want_mask, want_flush;

    always #1 i_clk = ~i_clk;

    function automatic t_out_item action_rec(logic [3:0] idx, logic [7:0] cnt, t_act a,
                                             logic [7:0] r, logic [7:0] c);
        t_out_item o;
        o = '0;
        o.dance_index_res = idx;
        o.taps_so_far = cnt;
        o.dance_action = a;
        o.row_res = r;
        o.col_res = c;
        return o;
    endfunction

    task automatic push_verdict(logic c, logic m, logic u, logic f);
        t_out_item o;
        o = '0;
        o.result_kind = 1;
        o.verdict = c;
        o.mask_key = m;
        o.unmask_key = u;
        o.flush_report = f;
        o.last = 1;
        expected_records.push_back(o);
    endtask

    task automatic tracker_reset();
        window_ms = 16'd200;
        act_valid = 0;
        act_idx = 0;
        act_row = 0;
        act_col = 0;
        deadline = 0;
        for (int k = 0; k < 16; k++) begin
            counts[k] = 0;
            held[k] = 0;
            fired[k] = 0;
            rel_pend[k] = 0;
        end
    endtask

    task automatic finish_dance(int k);
        deadline = 0;
        act_valid = 0;
        held[k] = 0;
        fired[k] = 0;
        rel_pend[k] = 1;
    endtask

    task automatic tap(logic [31:0] now);
        if (counts[act_idx] != 8'd255) counts[act_idx]++;
        deadline = now + 32'(window_ms);
        expected_records.push_back(action_rec(act_idx, counts[act_idx], ACT_TAP,
                                              act_row, act_col));
    endtask

    task automatic interrupt();
        expected_records.push_back(action_rec(act_idx, counts[act_idx], ACT_INTERRUPT,
                                              act_row, act_col));
        fired[act_idx] = 1;
        deadline = 0;
        want_mask = 1;
        want_flush = 1;
        if (!held[act_idx]) finish_dance(act_idx);
    endtask

    task automatic predict_tracker(t_in_item it);
        logic on, off;
        int t;
        on = it.now_pressed && !it.prev_pressed;
        off = !it.now_pressed && it.prev_pressed;
        t = it.dance_index;
        want_mask = 0;
        want_flush = 0;
        if (it.action) begin
            for (int k = 0; k < 16; k++) begin
                if (rel_pend[k]) begin
                    expected_records.push_back(action_rec(4'(k), counts[k], ACT_RELEASE,
                                                          act_row, act_col));
                    counts[k] = 0;
                    rel_pend[k] = 0;
                end
            end
            if (act_valid && deadline != 0 && it.now_ms > deadline) begin
                expected_records.push_back(action_rec(act_idx, counts[act_idx], ACT_TIMEOUT,
                                                      act_row, act_col));
                fired[act_idx] = 1;
                if (!held[act_idx]) finish_dance(act_idx);
            end
            push_verdict(0, want_mask, 0, want_flush);
            return;
        end
        if (it.injected) begin
            push_verdict(0, 0, 0, 0);
            return;
        end
        if (!it.key_is_dance) begin
            if (!act_valid) begin
                push_verdict(0, 0, 0, 0);
                return;
            end
            if (on) interrupt();
            if (it.key_masked || want_mask) push_verdict(1, want_mask, 1, want_flush);
            else push_verdict(0, want_mask, 0, want_flush);
            return;
        end
        if (off) held[t] = 0;
        if (!(act_valid && act_idx == 4'(t))) begin
            if (!act_valid) begin
                if (fired[t]) begin
                    if (off) finish_dance(t);
                    push_verdict(1, 0, 0, 0);
                    return;
                end
                act_valid = 1;
                act_idx = 4'(t);
                act_row = it.row;
                act_col = it.col;
                tap(it.now_ms);
                push_verdict(1, 0, 0, 0);
                return;
            end
            if (off && counts[t] != 0) begin
                finish_dance(t);
                push_verdict(1, 0, 0, 0);
                return;
            end
            if (!on) begin
                push_verdict(1, 0, 0, 0);
                return;
            end
            interrupt();
        end
        if (off) begin
            push_verdict(1, want_mask, 0, want_flush);
            return;
        end
        act_valid = 1;
        act_idx = 4'(t);
        act_row = it.row;
        act_col = it.col;
        held[t] = 1;
        if (on) tap(it.now_ms);
        else if (fired[t])
            expected_records.push_back(action_rec(4'(t), counts[t], ACT_HOLD, it.row, it.col));
        push_verdict(1, want_mask, 0, want_flush);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && in_valid && in_ready) predict_tracker(in_item);
    end

    always @(posedge i_clk) in_ready_seen <= i_rst_n && in_valid && in_ready;

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 0;
            in_item <= '0;
        end else if (!in_valid || in_ready_seen) begin
            if (in_wait > 0) begin
                in_wait <= in_wait - 1;
                in_valid <= 0;
            end else if (pending_events.size() > 0) begin
                in_item <= pending_events.pop_front();
                in_valid <= 1;
                in_wait <= $urandom_range(0, 8);
            end else begin
                in_valid <= 0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready) begin
            t_out_item e;
            if (expected_records.size() == 0) begin
                $error("unexpected record %p", out_item);
                fail_count++;
            end else begin
                e = expected_records.pop_front();
                if (out_item.result_kind !== e.result_kind) begin
                    $error("result_kind exp %0d got %0d", e.result_kind, out_item.result_kind);
                    fail_count++;
                end
                if (out_item.dance_index_res !== e.dance_index_res) begin
                    $error("dance_index_res exp %0d got %0d", e.dance_index_res,
                           out_item.dance_index_res);
                    fail_count++;
                end
                if (out_item.taps_so_far !== e.taps_so_far) begin
                    $error("taps_so_far exp %0d got %0d", e.taps_so_far, out_item.taps_so_far);
                    fail_count++;
                end
                if (out_item.dance_action !== e.dance_action) begin
                    $error("dance_action exp %0d got %0d", e.dance_action, out_item.dance_action);
                    fail_count++;
                end
                if (out_item.row_res !== e.row_res) begin
                    $error("row_res exp %0d got %0d", e.row_res, out_item.row_res);
                    fail_count++;
                end
                if (out_item.col_res !== e.col_res) begin
                    $error("col_res exp %0d got %0d", e.col_res, out_item.col_res);
                    fail_count++;
                end
                if (out_item.verdict !== e.verdict) begin
                    $error("verdict exp %0d got %0d", e.verdict, out_item.verdict);
                    fail_count++;
                end
                if (out_item.mask_key !== e.mask_key) begin
                    $error("mask_key exp %0d got %0d", e.mask_key, out_item.mask_key);
                    fail_count++;
                end
                if (out_item.unmask_key !== e.unmask_key) begin
                    $error("unmask_key exp %0d got %0d", e.unmask_key, out_item.unmask_key);
                    fail_count++;
                end
                if (out_item.flush_report !== e.flush_report) begin
                    $error("flush_report exp %0d got %0d", e.flush_report,
                           out_item.flush_report);
                    fail_count++;
                end
                if (out_item.last !== e.last) begin
                    $error("last exp %0d got %0d", e.last, out_item.last);
                    fail_count++;
                end
            end
        end
    end

    // receiver backpressure
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 0;
        end else if (stall_request && !stall_taken) begin
            stall_taken <= 1;
            stall_hold <= 300;
            out_ready <= 0;
        end else if (stall_hold > 0) begin
            stall_hold <= stall_hold - 1;
            out_ready <= (stall_hold == 1);
        end else if (out_wait > 0) begin
            out_wait <= out_wait - 1;
            out_ready <= 0;
        end else begin
            out_ready <= 1;
            if (out_valid) out_wait <= $urandom_range(0, 8);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready) ||
            !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic t_in_item make_event(logic act, logic dance, logic [3:0] idx,
                                            logic np, logic wp, logic [31:0] now);
        t_in_item it;
        it = '0;
        it.action = act;
        it.key_is_dance = dance;
        it.dance_index = idx;
        it.row = 8'($urandom);
        it.col = 8'($urandom);
        it.now_pressed = np;
        it.prev_pressed = wp;
        it.now_ms = now;
        return it;
    endfunction

    task automatic wait_drained();
        while (pending_events.size() > 0 || in_valid || expected_records.size() > 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_window(logic [15:0] v);
        @(negedge i_clk);
        cfg_data <= v;
        cfg_valid <= 1;
        do @(posedge i_clk); while (!cfg_ready);
        window_ms = v;
        @(negedge i_clk);
        cfg_valid <= 0;
    endtask

    task automatic random_phase(int n, logic [31:0] base, int step_max);
        logic [31:0] now;
        t_in_item it;
        int k;
        logic [63:0] raw;
        now = base;
        for (int j = 0; j < n; j++) begin
            k = $urandom_range(0, 3);
            now = now + $urandom_range(0, step_max);
            if ($urandom_range(0, 9) < 7) begin
                // well-formed: press, scans with optional holds, maybe an interrupting key, release, scan
                it = make_event(0, 1, 4'($urandom_range(0, 3) * 4 + k % 4), 1, 0, now);
                pending_events.push_back(it);
                for (int s = $urandom_range(0, 3); s > 0; s--) begin
                    now = now + $urandom_range(0, step_max);
                    pending_events.push_back(make_event(1, 0, 0, 0, 0, now));
                    if ($urandom_range(0, 1))
                        pending_events.push_back(make_event(0, it.key_is_dance,
                                                            it.dance_index, 1, 1, now));
                end
                if ($urandom_range(0, 3) == 0)
                    pending_events.push_back(make_event(0, 0, 0, 1, 0, now));
                pending_events.push_back(make_event(0, 1, it.dance_index, 0, 1, now));
                pending_events.push_back(make_event(1, 0, 0, 0, 0, now));
            end else begin
                raw = {$urandom, $urandom};
                it = raw[$bits(t_in_item)-1:0];
                it.now_ms = now;
                pending_events.push_back(it);
            end
        end
    endtask

    initial begin
        t_in_item it;
        i_rst_n = 0;
        cfg_valid = 0;
        cfg_data = '0;
        tracker_reset();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // directed: taps, hold, timeout while held, interrupts, injected, wrap
        pending_events.push_back(make_event(0, 1, 4'd15, 1, 0, 32'd100));
        pending_events.push_back(make_event(0, 1, 4'd15, 1, 1, 32'd110));
        pending_events.push_back(make_event(1, 0, 0, 0, 0, 32'd400));
        pending_events.push_back(make_event(0, 1, 4'd15, 1, 1, 32'd410));
        pending_events.push_back(make_event(1, 0, 0, 0, 0, 32'd500));
        pending_events.push_back(make_event(0, 1, 4'd15, 0, 1, 32'd510));
        pending_events.push_back(make_event(1, 0, 0, 0, 0, 32'd520));
        pending_events.push_back(make_event(0, 1, 4'd0, 1, 0, 32'd600));
        it = make_event(0, 0, 4'd7, 1, 0, 32'd601);
        it.key_masked = 1;
        pending_events.push_back(it);
        pending_events.push_back(make_event(0, 1, 4'd0, 0, 1, 32'd602));
        pending_events.push_back(make_event(1, 0, 0, 0, 0, 32'd603));
        pending_events.push_back(make_event(0, 1, 4'd3, 1, 0, 32'hFFFF_FF40));
        pending_events.push_back(make_event(0, 1, 4'd4, 1, 0, 32'hFFFF_FF41));
        it = make_event(0, 1, 4'd5, 1, 0, 32'hFFFF_FF42);
        it.injected = 1;
        pending_events.push_back(it);
        pending_events.push_back(make_event(1, 0, 0, 0, 0, 32'hFFFF_FFFF));
        pending_events.push_back(make_event(0, 1, 4'd4, 0, 1, 32'd5));
        pending_events.push_back(make_event(1, 0, 0, 0, 0, 32'd6));
        for (int j = 0; j < 6; j++) pending_events.push_back(make_event(0, 1, 4'd9, 1, 0, 32'd7));
        wait_drained();

        // saturate the count, then time out while held and after release
        write_window(16'd0);
        for (int j = 0; j < 258; j++)
            pending_events.push_back(make_event(0, 1, 4'd2, 1, 0, 32'd10));
        pending_events.push_back(make_event(1, 0, 0, 0, 0, 32'd11));
        pending_events.push_back(make_event(1, 0, 0, 0, 0, 32'd12));
        pending_events.push_back(make_event(0, 1, 4'd2, 0, 1, 32'd13));
        pending_events.push_back(make_event(1, 0, 0, 0, 0, 32'd14));
        pending_events.push_back(make_event(1, 0, 0, 0, 0, 32'd15));
        wait_drained();

        write_window(16'hFFFF);
        stall_request = 1;
        random_phase(10, 32'd1000, 20000);
        wait_drained();

        write_window(16'd200);
        random_phase(10, 32'hFFFF_0000, 150);
        wait_drained();

        write_window(16'($urandom_range(1, 30)));
        random_phase(10, 32'($urandom), 25);
        wait_drained();

        if (fail_count == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end
endmodule
